[rtl/gfc_pkg.sv]
// Package with the widths, register indexes and reset values of the gated frequency counter.
package gfc_pkg;

  localparam int unsigned COUNT_BITS   = 32;
  localparam int unsigned GATE_BITS    = 25;
  localparam int unsigned SCALE_BITS   = 4;
  localparam int unsigned PHASE_BITS   = 3;
  localparam int unsigned DATA_BITS    = 32;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] RegGateTicks      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] RegGateScale      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] RegPrescaleDiv8   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] RegSubtractOffset = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] RegOffsetHz       = 3'd4;

  localparam logic [GATE_BITS-1:0]  GateTicksReset = 25'd20000000;
  localparam logic [SCALE_BITS-1:0] GateScaleReset = 4'd1;
  localparam logic [DATA_BITS-1:0]  OffsetHzReset  = 32'd455000;

  typedef struct packed {
    logic [DATA_BITS-1:0] frequency_hz;
    logic [DATA_BITS-1:0] raw_count;
  } result_t;

endpackage

[rtl/gated_frequency_counter_core.sv]
// Gated frequency counter with optional prescaler, gate scale and offset subtraction.
//
// Each input word is one reference clock tick; signal_edge_i marks a rising edge of the
// measured signal during that tick. Words are taken with in_valid_i and in_stall_o and
// one word can be accepted in every cycle that in_stall_o is low. Edges pass an
// optional divide-by-8 prescaler and are counted while a gate of gate_ticks words is
// open. The word that closes a gate produces one result word: raw_count_o, the
// prescaled edge count, and frequency_hz_o, the count times prescale times gate_scale,
// less offset_hz when enabled, modulo 2^32. The next gate starts with the following word.
// A result word reaches out_valid_o through the counter stage and the output register:
// the accepting edge loads the closing count into the counter stage, and a later edge
// loads the multiply and subtract into the output register. A skid register behind the
// output register lets the counter stage drain while the receiver holds out_stall_i, so
// input is stalled only when output, skid and counter stage all hold results.
// Configuration is written with cfg_we_i, cfg_index_i and cfg_data_i; the user must do so
// only while the block is idle, which the block itself does not enforce. Reset clears
// the counters and empties the pipeline, and loads the registers with a one-second gate
// at 20 MHz, unit scale, no prescaler and a 455 kHz offset that is not subtracted.
module gated_frequency_counter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           signal_edge_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gfc_pkg::DATA_BITS-1:0]  frequency_hz_o,
  output logic [gfc_pkg::DATA_BITS-1:0]  raw_count_o,
  input  logic                           cfg_we_i,
  input  logic [gfc_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [gfc_pkg::DATA_BITS-1:0]  cfg_data_i
);

  logic [gfc_pkg::GATE_BITS-1:0]  gate_ticks_q;
  logic [gfc_pkg::SCALE_BITS-1:0] gate_scale_q;
  logic                           prescale_div8_q;
  logic                           subtract_offset_q;
  logic [gfc_pkg::DATA_BITS-1:0]  offset_hz_q;

  logic [gfc_pkg::GATE_BITS-1:0]  gate_cnt_q, gate_cnt_d;
  logic [gfc_pkg::COUNT_BITS-1:0] edge_cnt_q, edge_cnt_d, edge_cnt_inc;
  logic [gfc_pkg::PHASE_BITS-1:0] phase_q, phase_d, phase_inc;
  logic [gfc_pkg::GATE_BITS-1:0]  limit;
  logic [gfc_pkg::GATE_BITS:0]    gate_next;
  logic                           carry;
  logic                           close;
  logic                           accept;

  logic                           a_valid_q, a_valid_d;
  logic [gfc_pkg::DATA_BITS-1:0]  a_count_q, a_count_d;
  logic                           a_pre_q, a_pre_d;
  logic                           a_drain;

  logic [gfc_pkg::DATA_BITS-1:0]  scaled;
  logic [gfc_pkg::DATA_BITS-1:0]  product;
  gfc_pkg::result_t               a_res;

  logic                           out_valid_q, out_valid_d;
  logic                           skid_valid_q, skid_valid_d;
  gfc_pkg::result_t               out_q, out_d, skid_q, skid_d;
  logic                           out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_ticks_q      <= gfc_pkg::GateTicksReset;
      gate_scale_q      <= gfc_pkg::GateScaleReset;
      prescale_div8_q   <= 1'b0;
      subtract_offset_q <= 1'b0;
      offset_hz_q       <= gfc_pkg::OffsetHzReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gfc_pkg::RegGateTicks:      gate_ticks_q      <= cfg_data_i[gfc_pkg::GATE_BITS-1:0];
        gfc_pkg::RegGateScale:      gate_scale_q      <= cfg_data_i[gfc_pkg::SCALE_BITS-1:0];
        gfc_pkg::RegPrescaleDiv8:   prescale_div8_q   <= cfg_data_i[0];
        gfc_pkg::RegSubtractOffset: subtract_offset_q <= cfg_data_i[0];
        gfc_pkg::RegOffsetHz:       offset_hz_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Counter stage: edge prescaling, edge count and gate timing.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign a_drain    = out_load || !skid_valid_q;
  assign in_stall_o = a_valid_q && !a_drain;
  assign accept     = in_valid_i && !in_stall_o;

  assign limit     = (gate_ticks_q == '0) ? gfc_pkg::GATE_BITS'(1) : gate_ticks_q;
  assign gate_next = {1'b0, gate_cnt_q} + (gfc_pkg::GATE_BITS+1)'(1);
  assign close     = gate_next >= {1'b0, limit};
  assign phase_inc = phase_q + gfc_pkg::PHASE_BITS'(1);
  assign carry     = signal_edge_i && (!prescale_div8_q || phase_q == '1);
  assign edge_cnt_inc = edge_cnt_q + gfc_pkg::COUNT_BITS'(carry);

  always_comb begin
    gate_cnt_d = gate_cnt_q;
    edge_cnt_d = edge_cnt_q;
    phase_d    = phase_q;
    a_valid_d  = a_drain ? 1'b0 : a_valid_q;
    a_count_d  = a_count_q;
    a_pre_d    = a_pre_q;
    if (accept) begin
      if (close) begin
        gate_cnt_d = '0;
        edge_cnt_d = '0;
        phase_d    = '0;
        a_valid_d  = 1'b1;
        a_count_d  = gfc_pkg::DATA_BITS'(edge_cnt_inc);
        a_pre_d    = prescale_div8_q;
      end else begin
        gate_cnt_d = gate_next[gfc_pkg::GATE_BITS-1:0];
        edge_cnt_d = edge_cnt_inc;
        if (signal_edge_i && prescale_div8_q) begin
          phase_d = phase_inc;
        end
      end
    end
  end

  // Result arithmetic between the counter stage and the output registers.
  assign scaled  = a_pre_q ? {a_count_q[gfc_pkg::DATA_BITS-4:0], 3'b000} : a_count_q;
  assign product = scaled * {{(gfc_pkg::DATA_BITS-gfc_pkg::SCALE_BITS){1'b0}}, gate_scale_q};
  assign a_res.frequency_hz = subtract_offset_q ? product - offset_hz_q : product;
  assign a_res.raw_count    = a_count_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_load) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_d       = a_res;
        skid_valid_d = a_valid_q;
      end else if (a_valid_q) begin
        out_d       = a_res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (!skid_valid_q && a_valid_q) begin
      skid_d       = a_res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_cnt_q   <= '0;
      edge_cnt_q   <= '0;
      phase_q      <= '0;
      a_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      gate_cnt_q   <= gate_cnt_d;
      edge_cnt_q   <= edge_cnt_d;
      phase_q      <= phase_d;
      a_valid_q    <= a_valid_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_count_q <= a_count_d;
    a_pre_q   <= a_pre_d;
    out_q     <= out_d;
    skid_q    <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign frequency_hz_o = out_q.frequency_hz;
  assign raw_count_o    = out_q.raw_count;

endmodule
